// File: rtl/core/stw_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the stereo tremolo block.
// No dependencies; every other file of the block but stw_if uses this package.
package stw_pkg;

  // Q1.15 unity and related constants
  localparam logic [16:0] Q15_ONE          = 17'd32768;
  localparam logic [15:0] Q15_SAT          = 16'd32768;
  localparam logic [20:0] PHASE_STEP_RESET = 21'd48695;
  localparam logic [31:0] SEED_RESET       = 32'h9e37_79ba;
  localparam logic [18:0] SMOOTH_COEF      = 19'd33;

  // Frame queue between the front and back parts
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_PHASE_STEP  = 2'd0,
    REG_DEPTH       = 2'd1,
    REG_DRIFT_DEPTH = 2'd2
  } reg_idx_t;

  // Configuration register set
  typedef struct packed {
    logic [20:0] phase_step;
    logic [15:0] depth;
    logic [15:0] drift_depth;
  } cfg_t;

  // Queued frame with its drift class
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               drift;
  } frame_t;

  // Clip a Q1.15 register value to full scale
  function automatic logic [15:0] sat_q15(input logic [15:0] v);
    return (v > Q15_SAT) ? Q15_SAT : v;
  endfunction

  // One xorshift32 step, shifts 13, 17, 5
  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

// File: rtl/core/stw_if.sv
`timescale 1ns / 1ps
// Valid/ready channels for stereo frames into and out of the block.
// Depends on nothing but the language; used by the top level and its parts.
interface stw_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_in;
  logic signed [15:0] right_in;

  modport source (output valid, left_in, right_in, input ready);
  modport sink   (input valid, left_in, right_in, output ready);
endinterface

interface stw_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

// File: rtl/core/stw_front.sv
`timescale 1ns / 1ps
// Front part: takes frame requests, tags them with the drift class and
// queues them for the back part. Depends on stw_pkg and stw_if.
module stw_front (
  input  logic                clk,
  input  logic                rst,
  stw_in_if.sink              in_frame,
  input  stw_pkg::cfg_t       cfg,
  input  logic                pop,
  output logic                q_valid,
  output stw_pkg::frame_t     q_data
);

  stw_pkg::frame_t                   queue [stw_pkg::QDEPTH];
  logic [stw_pkg::QPTR_W-1:0]        wr_ptr;
  logic [stw_pkg::QPTR_W-1:0]        rd_ptr;
  logic [stw_pkg::QCNT_W-1:0]        count;
  logic                              push;
  logic                              pop_ok;

  // Accept while a slot is free
  assign in_frame.ready = (count != stw_pkg::QCNT_W'(stw_pkg::QDEPTH));
  assign push           = in_frame.valid && in_frame.ready;
  assign pop_ok         = pop && q_valid;
  assign q_valid        = (count != '0);
  assign q_data         = queue[rd_ptr];

  // Store the frame with its class
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{left:  in_frame.left_in,
                         right: in_frame.right_in,
                         drift: (stw_pkg::sat_q15(cfg.drift_depth) != '0)};
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == stw_pkg::QPTR_W'(stw_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == stw_pkg::QPTR_W'(stw_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= stw_pkg::QCNT_W'(stw_pkg::QDEPTH))
    else $error("frame queue count out of range");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (push && pop_ok) |=> $stable(count))
    else $error("simultaneous push and pop changed queue count");

endmodule

// File: rtl/core/stw_back.sv
`timescale 1ns / 1ps
// Back part: advances the LFO and drift state and scales each frame through
// one shared multiplier. Depends on stw_pkg and stw_if.
module stw_back (
  input  logic               clk,
  input  logic               rst,
  input  stw_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  stw_pkg::frame_t    q_data,
  output logic               pop,
  stw_out_if.source          out_frame
);

  typedef enum logic [2:0] {
    ST_LOAD, ST_SMOOTH, ST_DRIFT, ST_GAIN, ST_LEFT, ST_RIGHT, ST_DONE
  } state_t;

  state_t              state;
  logic [31:0]         lfo_phase;
  logic signed [23:0]  wander;
  logic [31:0]         noise_seed;

  logic signed [15:0]  l_r;
  logic signed [15:0]  r_r;
  logic                drift_r;
  logic [16:0]         tri_r;
  logic [24:0]         diff_r;
  logic [16:0]         g_r;
  logic [15:0]         left_res;
  logic signed [43:0]  prod;
  logic                out_valid;
  logic [15:0]         out_left;
  logic [15:0]         out_right;

  logic [31:0]         phase_next;
  logic [15:0]         u;
  logic [15:0]         a_abs;
  logic [16:0]         tri_calc;
  logic [31:0]         seed_next;
  logic [24:0]         noise_ext;
  logic [24:0]         diff_calc;
  logic [24:0]         w_sum;
  logic [23:0]         w_new;
  logic [18:0]         tri_sum;
  logic [16:0]         tri_c;
  logic [17:0]         tsum;
  logic [16:0]         g_calc;
  logic [15:0]         dep;
  logic [15:0]         drf;
  logic signed [24:0]  mul_a;
  logic signed [18:0]  mul_b;
  logic                mul_en;
  logic                out_free;

  assign dep      = stw_pkg::sat_q15(cfg.depth);
  assign drf      = stw_pkg::sat_q15(cfg.drift_depth);
  assign pop      = (state == ST_LOAD) && q_valid;
  assign out_free = !out_valid || out_frame.ready;

  // Phase and triangle
  always_comb begin
    phase_next = lfo_phase + {11'd0, cfg.phase_step};
    u          = phase_next[31:16];
    a_abs      = u[15] ? {1'b0, u[14:0]} : 16'(stw_pkg::Q15_ONE - {1'b0, u});
    tri_calc   = {a_abs, 1'b0} - stw_pkg::Q15_ONE;
  end

  // Noise and smoother input
  always_comb begin
    seed_next = stw_pkg::xorshift32(noise_seed);
    noise_ext = {{2{~seed_next[31]}}, ~seed_next[31], seed_next[30:9]};
    diff_calc = noise_ext - {wander[23], wander};
  end

  // Wander update, drift add with clamp, gain
  always_comb begin
    w_sum   = {wander[23], wander} + prod[39:15];
    w_new   = w_sum[23:0];
    tri_sum = {{2{tri_r[16]}}, tri_r} + prod[40:22];
    priority if (drift_r && ($signed(tri_sum) > 19'sd32768)) begin
      tri_c = stw_pkg::Q15_ONE;
    end else if (drift_r && ($signed(tri_sum) < -19'sd32768)) begin
      tri_c = 17'(-19'sd32768);
    end else if (drift_r) begin
      tri_c = tri_sum[16:0];
    end else begin
      tri_c = tri_r;
    end
    tsum   = {tri_c[16], tri_c} + {1'b0, stw_pkg::Q15_ONE};
    g_calc = stw_pkg::Q15_ONE - {1'b0, prod[31:16]};
  end

  // Select operands of the shared multiplier
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (state)
      ST_SMOOTH: begin
        mul_a = $signed(diff_r);
        mul_b = $signed(stw_pkg::SMOOTH_COEF);
      end
      ST_DRIFT: begin
        mul_a = $signed({w_new[23], w_new});
        mul_b = $signed({3'd0, drf});
      end
      ST_GAIN: begin
        mul_a = $signed({7'd0, tsum});
        mul_b = $signed({3'd0, dep});
      end
      ST_LEFT: begin
        mul_a = $signed({{9{l_r[15]}}, l_r});
        mul_b = $signed({2'd0, g_calc});
      end
      ST_RIGHT: begin
        mul_a = $signed({{9{r_r[15]}}, r_r});
        mul_b = $signed({2'd0, g_r});
      end
      ST_LOAD, ST_DONE: begin
        mul_en = 1'b0;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Hold the product for the next step
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // Sequencer, LFO state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      lfo_phase  <= '0;
      wander     <= '0;
      noise_seed <= stw_pkg::SEED_RESET;
      out_valid  <= 1'b0;
    end else begin
      // Drop a taken result; the done step reloads the register itself
      if (out_valid && out_frame.ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (q_valid) begin
            l_r       <= q_data.left;
            r_r       <= q_data.right;
            drift_r   <= q_data.drift;
            lfo_phase <= phase_next;
            tri_r     <= tri_calc;
            if (q_data.drift) begin
              noise_seed <= seed_next;
              diff_r     <= diff_calc;
              state      <= ST_SMOOTH;
            end else begin
              state <= ST_GAIN;
            end
          end
        end
        ST_SMOOTH: begin
          state <= ST_DRIFT;
        end
        ST_DRIFT: begin
          wander <= w_new;
          state  <= ST_GAIN;
        end
        ST_GAIN: begin
          state <= ST_LEFT;
        end
        ST_LEFT: begin
          g_r   <= g_calc;
          state <= ST_RIGHT;
        end
        ST_RIGHT: begin
          left_res <= prod[30:15];
          state    <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_left  <= left_res;
            out_right <= prod[30:15];
            out_valid <= 1'b1;
            state     <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_frame.valid     = out_valid;
  assign out_frame.left_out  = $signed(out_left);
  assign out_frame.right_out = $signed(out_right);

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LEFT) |-> (g_calc <= stw_pkg::Q15_ONE))
    else $error("tremolo gain above unity");

  a_wander_range: assert property (@(posedge clk) disable iff (rst)
    ($signed(wander) <= 24'sd4194304) && ($signed(wander) >= -24'sd4194304))
    else $error("smoothed noise out of range");

  a_drift_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD && q_valid && !q_data.drift) |=>
      ($stable(wander) && $stable(noise_seed)))
    else $error("drift state moved with drift off");

endmodule

// File: rtl/core/stereo_tremolo_with_drift.sv
`timescale 1ns / 1ps
// Stereo tremolo with random drift: APB registers, frame queue, back part.
// Sequence per frame: load, gain, left, right, done; with drift on, smooth and drift follow load.
// The back part takes the next frame only once done has passed on the last one; done waits for out ready.
// A 2-entry queue takes requests while the back part works.
// Reset (rst, synchronous) restores register defaults, LFO phase, noise seed and wander.
module stereo_tremolo_with_drift (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  stw_in_if.sink       in_frame,
  stw_out_if.source    out_frame
);

  stw_pkg::cfg_t      cfg;
  stw_pkg::frame_t    q_data;
  stw_pkg::reg_idx_t  reg_idx;
  logic               q_valid;
  logic               pop;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = stw_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step  <= stw_pkg::PHASE_STEP_RESET;
      cfg.depth       <= '0;
      cfg.drift_depth <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        stw_pkg::REG_PHASE_STEP:  cfg.phase_step  <= pwdata[20:0];
        stw_pkg::REG_DEPTH:       cfg.depth       <= pwdata[15:0];
        stw_pkg::REG_DRIFT_DEPTH: cfg.drift_depth <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      stw_pkg::REG_PHASE_STEP:  prdata = {11'd0, cfg.phase_step};
      stw_pkg::REG_DEPTH:       prdata = {16'd0, cfg.depth};
      stw_pkg::REG_DRIFT_DEPTH: prdata = {16'd0, cfg.drift_depth};
      default:                  prdata = '0;
    endcase
  end

  stw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_frame (in_frame),
    .cfg      (cfg),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_data   (q_data)
  );

  stw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_frame (out_frame)
  );

endmodule

// File: tb/stw_tremolo_check.sv
`timescale 1ns / 1ps
// Watches the stereo tremolo channels and register port and predicts each scaled frame.
// Depends on stw_pkg and the stw_in_if / stw_out_if channel interfaces.
module stw_tremolo_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  stw_in_if           in_frame,
  stw_out_if          out_frame,
  output int unsigned frames_pending,
  output int unsigned errors
);

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } stereo_t;

  // Shadow registers, as written through the register port
  logic [20:0] step_r;
  logic [15:0] depth_r;
  logic [15:0] drift_r;

  // LFO, smoother and noise generator state
  logic [31:0] lfo_phase;
  longint      wander;
  logic [31:0] noise_seed;

  stereo_t scaled_q[$];

  // Advance the LFO by one frame and scale both samples by its gain
  function automatic stereo_t tremolo_frame(input logic signed [15:0] l,
                                            input logic signed [15:0] r);
    longint      wave;
    longint      u;
    longint      dep;
    longint      drf;
    longint      noise;
    longint      gain;
    logic [31:0] x;
    stereo_t     res;
    dep = (depth_r > stw_pkg::Q15_SAT) ? longint'(stw_pkg::Q15_SAT) : longint'(depth_r);
    drf = (drift_r > stw_pkg::Q15_SAT) ? longint'(stw_pkg::Q15_SAT) : longint'(drift_r);

    // triangle from the top half of the phase, -1..+1 in Q1.15
    lfo_phase = lfo_phase + {11'd0, step_r};
    u = longint'(lfo_phase[31:16]);
    wave = u - 32768;
    if (wave < 0) wave = -wave;
    wave = 2 * wave - 32768;

    // random wander only runs while drift is enabled
    if (drf != 0) begin
      x = noise_seed;
      x ^= x << 13;
      x ^= x >> 17;
      x ^= x << 5;
      noise_seed = x;
      noise = longint'(x[31:9]);
      noise = noise - 4194304;
      wander = wander + ((33 * (noise - wander)) >>> 15);
      wave = wave + ((wander * drf) >>> 22);
      if (wave > 32768) wave = 32768;
      if (wave < -32768) wave = -32768;
    end

    gain = 32768 - ((dep * (32768 + wave)) >>> 16);
    res.left  = 16'((longint'(l) * gain) >>> 15);
    res.right = 16'((longint'(r) * gain) >>> 15);
    return res;
  endfunction

  always @(posedge clk) begin : track
    stereo_t want;
    if (rst) begin
      step_r     = stw_pkg::PHASE_STEP_RESET;
      depth_r    = 16'd0;
      drift_r    = 16'd0;
      lfo_phase  = 32'd0;
      wander     = 0;
      noise_seed = stw_pkg::SEED_RESET;
      errors     = 0;
      scaled_q.delete();
    end else begin
      // mirror register writes; unmapped indexes fall through
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          stw_pkg::REG_PHASE_STEP:  step_r  = pwdata[20:0];
          stw_pkg::REG_DEPTH:       depth_r = pwdata[15:0];
          stw_pkg::REG_DRIFT_DEPTH: drift_r = pwdata[15:0];
          default: ;
        endcase
      end

      if (in_frame.valid && in_frame.ready)
        scaled_q.push_back(tremolo_frame(in_frame.left_in, in_frame.right_in));

      // compare each result with the oldest prediction
      if (out_frame.valid && out_frame.ready) begin
        if (scaled_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result left=%0d right=%0d", $time,
                   out_frame.left_out, out_frame.right_out);
        end else begin
          want = scaled_q.pop_front();
          if (out_frame.left_out !== want.left) begin
            errors++;
            $display("%0t: left_out expected %0d actual %0d", $time,
                     want.left, out_frame.left_out);
          end
          if (out_frame.right_out !== want.right) begin
            errors++;
            $display("%0t: right_out expected %0d actual %0d", $time,
                     want.right, out_frame.right_out);
          end
        end
      end
    end
    frames_pending <= scaled_q.size();
  end

endmodule

// File: tb/stereo_tremolo_with_drift_tb.sv
`timescale 1ns / 1ps
// Top of the stereo tremolo testbench: clock, reset, register writes, frame traffic, verdict.
// Depends on stw_pkg, the channel interfaces, the block and stw_tremolo_check.
module stereo_tremolo_with_drift_tb;

  localparam int unsigned  WATCHDOG_LIMIT = 2000;
  localparam int unsigned  DRAIN_CYCLES   = 12;
  localparam int unsigned  RANDOM_PHASES  = 10;
  localparam int unsigned  PHASE_FRAMES   = 175;
  localparam logic [20:0]  STEP_MAX       = 21'h1F_FFFF;
  localparam logic [15:0]  Q15_FULL       = 16'd32768;
  localparam logic [3:0]   ADDR_UNMAPPED  = 4'hC;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned frames_pending;
  int unsigned errors;
  int unsigned idle_cycles;
  bit          tx_quiet;
  bit          rx_quiet;

  stw_in_if  in_bus ();
  stw_out_if out_bus ();

  stereo_tremolo_with_drift DUT (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_frame  (in_bus),
    .out_frame (out_bus)
  );

  stw_tremolo_check tremolo_check (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .in_frame       (in_bus),
    .out_frame      (out_bus),
    .frames_pending (frames_pending),
    .errors         (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // After each accepted result, stall the result side for a random hold unless rx_quiet is set
  initial begin : result_sink
    int unsigned hold;
    out_bus.ready <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        hold = 0;
      end else if (out_bus.ready && out_bus.valid) begin
        hold = rx_quiet ? 0 : $urandom_range(0, 5);
        if (hold != 0) out_bus.ready <= 1'b0;
      end else if (!out_bus.ready) begin
        if (hold <= 1) out_bus.ready <= 1'b1;
        if (hold != 0) hold--;
      end
    end
  end

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic logic [3:0] reg_addr(input stw_pkg::reg_idx_t idx);
    return {idx, 2'b00};
  endfunction

  // Setup, access, then idle before the next transfer
  task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write all three registers; bits above each field carry junk that must be dropped
  task automatic program_lfo(input logic [20:0] step, input logic [15:0] dep,
                             input logic [15:0] drift);
    reg_write(reg_addr(stw_pkg::REG_PHASE_STEP), ($urandom & 32'hFFE0_0000) | step);
    reg_write(reg_addr(stw_pkg::REG_DEPTH), ($urandom & 32'hFFFF_0000) | dep);
    reg_write(reg_addr(stw_pkg::REG_DRIFT_DEPTH), ($urandom & 32'hFFFF_0000) | drift);
  endtask

  task automatic send_frame(input logic signed [15:0] l, input logic signed [15:0] r);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.left_in  <= l;
    in_bus.right_in <= r;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // Drop valid, wait for every prediction to be matched, then let the pipe empty
  task automatic settle();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (frames_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_extremes();
    send_frame(-16'sd32768, 16'sd32767);
    send_frame(16'sd32767, -16'sd32768);
    send_frame(16'sd0, 16'sd0);
    send_frame(-16'sd1, 16'sd1);
  endtask

  // Mostly full-range samples, now and then a rail value
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_q15();
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return Q15_FULL;
      2:       return 16'($urandom_range(32769, 65535));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [20:0] pick_step();
    case ($urandom_range(0, 4))
      0:       return 21'd0;
      1:       return STEP_MAX;
      2:       return 21'($urandom_range(0, 2097151));
      default: return 21'($urandom_range(262144, 2097151));
    endcase
  endfunction

  initial begin : stimulus
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_bus.valid    <= 1'b0;
    in_bus.left_in  <= '0;
    in_bus.right_in <= '0;
    tx_quiet        = 1'b0;
    rx_quiet        = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: zero depth, so frames pass through unchanged
    send_extremes();
    settle();

    // full depth with the fastest LFO
    program_lfo(STEP_MAX, Q15_FULL, 16'd0);
    send_extremes();
    settle();

    // depth and drift above full scale saturate; phase frozen
    program_lfo(21'd0, 16'hFFFF, 16'hFFFF);
    send_extremes();
    settle();

    // write to an unmapped index must change nothing; smallest drift
    reg_write(ADDR_UNMAPPED, $urandom);
    program_lfo(stw_pkg::PHASE_STEP_RESET, 16'($urandom_range(0, 32768)), 16'd1);
    repeat (4) send_frame(pick_sample(), pick_sample());
    settle();

    // random settings, some phases run back to back with no idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_lfo(pick_step(), pick_q15(), pick_q15());
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      repeat (PHASE_FRAMES) send_frame(pick_sample(), pick_sample());
      settle();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/stw_pkg.sv
rtl/core/stw_if.sv
rtl/core/stw_front.sv
rtl/core/stw_back.sv
rtl/core/stereo_tremolo_with_drift.sv
tb/stw_tremolo_check.sv
tb/stereo_tremolo_with_drift_tb.sv
